[src/hex_ascii_frame_receiver_defines.svh]
// Assertion macros shared by the checker file.
`ifndef HEX_ASCII_FRAME_RECEIVER_DEFINES_SVH
`define HEX_ASCII_FRAME_RECEIVER_DEFINES_SVH

// Property checked only while out of reset.
`define HAFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define HAFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/hafr_pkg.sv]
package hafr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HUNT = 2'd1,
    PH_CMD  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    FUNC_ARM  = 2'd0,
    FUNC_CHAR = 2'd1,
    FUNC_TICK = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_SUM  = 2'd3
  } status_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic REG_CHECK_MAGIC   = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam int COUNT_W = 8;
  localparam int TICK_W  = 16;

  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [1:0]         status;
    logic [3:0]         command_nibble;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] char_count;
  } result_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      n = c[3:0] + 4'd9;
    end
    return n;
  endfunction

endpackage

[src/hafr_frame.sv]
module hafr_frame #(
  parameter int MAX_CHARS = 100
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [1:0]              func,
  input  logic [7:0]              rx_char,
  input  logic [7:0]              check_magic,
  input  logic [15:0]             timeout_ticks,
  output hafr_pkg::result_t       res
);
  import hafr_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_CHARS);

  phase_t              phase, phase_next;
  logic [COUNT_W-1:0]  stored_count, stored_count_next;
  logic [7:0]          running_sum, running_sum_next;
  logic [3:0]          pending_high_nibble, pending_high_nibble_next;
  logic                nibble_waiting, nibble_waiting_next;
  logic [TICK_W-1:0]   tick_counter, tick_counter_next;
  logic [3:0]          frame_command, frame_command_next;

  logic [3:0]          nib;
  logic [7:0]          byte_val;
  logic [COUNT_W-1:0]  count_inc;
  logic                in_frame;
  logic                is_newline;
  logic                is_overflow;
  logic                is_timeout;

  assign nib         = hex_nibble(rx_char);
  assign byte_val    = {pending_high_nibble, nib};
  assign count_inc   = stored_count + COUNT_W'(1);
  assign in_frame    = (phase == PH_CMD) || (phase == PH_DATA);
  assign is_newline  = (rx_char == CHAR_NEWLINE);
  assign is_overflow = count_inc >= MaxCount;
  assign is_timeout  = tick_counter >= timeout_ticks;

  always_comb begin
    phase_next               = phase;
    stored_count_next        = stored_count;
    running_sum_next         = running_sum;
    pending_high_nibble_next = pending_high_nibble;
    nibble_waiting_next      = nibble_waiting;
    tick_counter_next        = tick_counter;
    frame_command_next       = frame_command;
    if (accept) begin
      case (func)
        FUNC_ARM: begin
          phase_next               = PH_HUNT;
          stored_count_next        = '0;
          running_sum_next         = '0;
          pending_high_nibble_next = '0;
          nibble_waiting_next      = 1'b0;
          tick_counter_next        = '0;
          frame_command_next       = '0;
        end
        FUNC_TICK: begin
          if (phase != PH_IDLE) begin
            if (is_timeout) begin
              phase_next = PH_IDLE;
            end else begin
              tick_counter_next = tick_counter + TICK_W'(1);
            end
          end
        end
        FUNC_CHAR: begin
          if (phase == PH_HUNT) begin
            if (rx_char == CHAR_COLON) begin
              stored_count_next = COUNT_W'(1);
              phase_next        = PH_CMD;
            end
          end else if (in_frame) begin
            if (is_newline) begin
              phase_next = PH_IDLE;
            end else begin
              stored_count_next = count_inc;
              if (is_overflow) begin
                phase_next = PH_IDLE;
              end else if (phase == PH_CMD) begin
                frame_command_next = nib;
                running_sum_next   = {4'd0, nib};
                phase_next         = PH_DATA;
              end else if (!nibble_waiting) begin
                pending_high_nibble_next = nib;
                nibble_waiting_next      = 1'b1;
              end else begin
                nibble_waiting_next = 1'b0;
                running_sum_next    = running_sum + byte_val;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res                = '0;
    res.command_nibble = frame_command;
    if (accept && func == FUNC_TICK && phase != PH_IDLE && is_timeout) begin
      res.valid      = 1'b1;
      res.kind       = KIND_END;
      res.status     = ST_TIMEOUT;
      res.char_count = stored_count;
    end else if (accept && func == FUNC_CHAR && in_frame) begin
      if (is_newline) begin
        res.valid      = 1'b1;
        res.kind       = KIND_END;
        res.status     = (running_sum == check_magic) ? ST_OK : ST_BAD_SUM;
        res.char_count = stored_count;
      end else if (is_overflow) begin
        res.valid      = 1'b1;
        res.kind       = KIND_END;
        res.status     = ST_OVERFLOW;
        res.char_count = count_inc;
      end else if (phase == PH_DATA && nibble_waiting) begin
        res.valid     = 1'b1;
        res.kind      = KIND_DATA;
        res.data_byte = byte_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      stored_count        <= '0;
      running_sum         <= '0;
      pending_high_nibble <= '0;
      nibble_waiting      <= 1'b0;
      tick_counter        <= '0;
      frame_command       <= '0;
    end else begin
      phase               <= phase_next;
      stored_count        <= stored_count_next;
      running_sum         <= running_sum_next;
      pending_high_nibble <= pending_high_nibble_next;
      nibble_waiting      <= nibble_waiting_next;
      tick_counter        <= tick_counter_next;
      frame_command       <= frame_command_next;
    end
  end

endmodule

[src/hex_ascii_frame_receiver.sv]
// Receiver for ASCII hex response frames of the form ':' C HH .. HH '\n'.
// Input stream: one word per character or timer event. s_tuser carries the
// function (arm, character, tick), s_tdata the character. An arm word
// starts a receive and restarts the timeout count.
// Output stream: m_tuser is the kind (decoded byte or frame end), m_tdata
// holds status, command nibble, data byte and character count.
// Throughput: one input word per cycle unless the output stalls. A word is
// decoded in the cycle it is accepted; its result, if any, sits in the output
// register on the next cycle. The output register is the only buffer:
// s_tready drops only while it holds a result and m_tready is low.
// Configuration: cfg_we writes check value (index 0) or timeout ticks
// (index 1); write only while no frame is active.
// Reset: the receiver goes idle and ignores characters and ticks until the
// next arm word; registers return to check value 85 and 1000 ticks, and the
// output register empties.
module hex_ascii_frame_receiver #(
  parameter int MAX_CHARS = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_char
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [1:0] status, [5:2] command_nibble,
                                 // [13:6] data_byte, [21:14] char_count, [23:22] zero
  output logic        m_tuser,   // [0] kind
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import hafr_pkg::*;

  logic [7:0]  check_magic;
  logic [15:0] timeout_ticks;
  logic        accept;
  result_t     res;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_magic   <= 8'd85;
      timeout_ticks <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHECK_MAGIC:   check_magic   <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  hafr_frame #(
    .MAX_CHARS(MAX_CHARS)
  ) u_frame (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .func         (s_tuser),
    .rx_char      (s_tdata),
    .check_magic  (check_magic),
    .timeout_ticks(timeout_ticks),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      m_tuser <= res.kind;
      m_tdata <= {2'b00, res.char_count, res.data_byte, res.command_nibble, res.status};
    end
  end

endmodule

[src/hafr_checker.sv]
`include "hex_ascii_frame_receiver_defines.svh"

module hafr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);
  import hafr_pkg::*;

  `HAFR_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")
  `HAFR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")
  `HAFR_ASSERT(a_ready_when_empty, clk, rst, !m_tvalid || m_tready |-> s_tready, "input stalled with free output register")
  `HAFR_ASSERT(a_data_fields, clk, rst, m_tvalid && m_tuser == KIND_DATA |-> m_tdata[1:0] == ST_OK && m_tdata[21:14] == 8'd0, "data word with status or count")
  `HAFR_ASSERT(a_end_fields, clk, rst, m_tvalid && m_tuser == KIND_END |-> m_tdata[13:6] == 8'd0, "frame end with data byte")

endmodule

bind hex_ascii_frame_receiver hafr_checker u_hafr_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
